// File: rtl/trail_segment_collision_core_macros.svh
// Assertion macros for the trail segment collision core.
// Used by the top level; expects clk and rst_n at the point of use.
`ifndef TRAIL_SEGMENT_COLLISION_CORE_MACROS_SVH
`define TRAIL_SEGMENT_COLLISION_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TSC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define TSC_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tsc_pkg.sv
// Shared types and constants for the trail segment collision core.
// No dependencies.
package tsc_pkg;

  // Parameter defaults
  localparam int TRAILS_DEF = 4;
  localparam int PPT_DEF    = 1024;

  // Field widths
  localparam int ACT_W = 2;
  localparam int TID_W = 2;
  localparam int CRD_W = 16;   // Q8.8 coordinate
  localparam int PC_W  = 11;   // reported point count
  localparam int PT_W  = 2 * CRD_W;

  // Arithmetic widths of the crossing test
  localparam int DIF_W = CRD_W + 1;        // coordinate difference
  localparam int CP_W  = 2 * CRD_W;        // coordinate product
  localparam int CA_W  = CP_W + 1;         // cross term of one segment
  localparam int DP_W  = 2 * DIF_W;        // difference product
  localparam int DET_W = DP_W + 1;         // determinant
  localparam int NP_W  = DIF_W + CA_W;     // numerator product
  localparam int CMP_W = NP_W + 2;         // numerator, bounds, compares

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } act_t;

  // Query segment terms, fixed for the whole walk
  typedef struct packed {
    logic signed [CRD_W-1:0] qxl;
    logic signed [CRD_W-1:0] qxh;
    logic signed [CRD_W-1:0] qyl;
    logic signed [CRD_W-1:0] qyh;
    logic signed [DIF_W-1:0] dxa;
    logic signed [DIF_W-1:0] dya;
    logic signed [CA_W-1:0]  ca;
  } qry_t;

  // Crossing pipeline status
  typedef struct packed {
    logic busy;
    logic hit;
  } pipe_stat_t;

endpackage

// File: rtl/tsc_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on tsc_pkg for field widths.
interface tsc_in_if;
  logic                              valid;
  logic                              ready;
  logic [tsc_pkg::ACT_W-1:0]         action;
  logic [tsc_pkg::TID_W-1:0]         trail_id;
  logic signed [tsc_pkg::CRD_W-1:0]  x_first;
  logic signed [tsc_pkg::CRD_W-1:0]  y_first;
  logic signed [tsc_pkg::CRD_W-1:0]  x_second;
  logic signed [tsc_pkg::CRD_W-1:0]  y_second;

  modport source (output valid, action, trail_id, x_first, y_first, x_second, y_second,
                  input ready);
  modport sink   (input valid, action, trail_id, x_first, y_first, x_second, y_second,
                  output ready);
endinterface

interface tsc_out_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [tsc_pkg::PC_W-1:0] point_count;
  logic                     dropped;

  modport source (output valid, hit, point_count, dropped, input ready);
  modport sink   (input valid, hit, point_count, dropped, output ready);
endinterface

// File: rtl/tsc_point_mem.sv
// Point store: single write port, single read port, registered read data.
// Depends on tsc_pkg for the point word width.
module tsc_point_mem #(
  parameter int DEPTH = tsc_pkg::TRAILS_DEF * tsc_pkg::PPT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [tsc_pkg::PT_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [tsc_pkg::PT_W-1:0] rdata
);

  logic [tsc_pkg::PT_W-1:0] mem [DEPTH];
  logic [tsc_pkg::PT_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tsc_seg_pipe.sv
// Segment crossing pipeline: one stored segment per cycle, sticky hit flag.
// Depends on tsc_pkg for arithmetic widths and the query/status structs.
module tsc_seg_pipe (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     vld,
  input  logic                     first,
  input  logic [tsc_pkg::PT_W-1:0] pt,
  input  tsc_pkg::qry_t            qry,
  output tsc_pkg::pipe_stat_t      stat
);

  localparam int CRD_W = tsc_pkg::CRD_W;
  localparam int DIF_W = tsc_pkg::DIF_W;
  localparam int CP_W  = tsc_pkg::CP_W;
  localparam int CA_W  = tsc_pkg::CA_W;
  localparam int DP_W  = tsc_pkg::DP_W;
  localparam int DET_W = tsc_pkg::DET_W;
  localparam int NP_W  = tsc_pkg::NP_W;
  localparam int CMP_W = tsc_pkg::CMP_W;

  // Previous point of the trail
  logic [tsc_pkg::PT_W-1:0] prev_r;

  logic signed [CRD_W-1:0] px, py, qx, qy;
  assign px = prev_r[CRD_W-1:0];
  assign py = prev_r[2*CRD_W-1:CRD_W];
  assign qx = pt[CRD_W-1:0];
  assign qy = pt[2*CRD_W-1:CRD_W];

  // Stage 1: differences and cross products of the stored segment
  logic                    v1_r;
  logic signed [CRD_W-1:0] x3_1_r, y3_1_r, x4_1_r, y4_1_r;
  logic signed [DIF_W-1:0] dxb1_r, dyb1_r;
  logic signed [CP_W-1:0]  m1_1_r, m2_1_r;

  // Stage 2: cross term, determinant products
  logic                    v2_r;
  logic signed [CRD_W-1:0] x3_2_r, y3_2_r, x4_2_r, y4_2_r;
  logic signed [DIF_W-1:0] dxb2_r, dyb2_r;
  logic signed [CA_W-1:0]  cb2_r;
  logic signed [DP_W-1:0]  pd1_2_r, pd2_2_r;

  // Stage 3: determinant, numerator products
  logic                    v3_r;
  logic signed [CRD_W-1:0] x3_3_r, y3_3_r, x4_3_r, y4_3_r;
  logic signed [DET_W-1:0] det3_r;
  logic signed [NP_W-1:0]  na3_r, nb3_r, nc3_r, nd3_r;

  // Stage 4: sign-normalized numerators and determinant, segment bounds
  logic                    v4_r;
  logic signed [DET_W-1:0] adet4_r;
  logic signed [CMP_W-1:0] nx4_r, ny4_r;
  logic signed [CRD_W-1:0] bxl4_r, bxh4_r, byl4_r, byh4_r;

  // Stage 5: bounds scaled by the determinant
  logic                    v5_r;
  logic signed [CMP_W-1:0] nx5_r, ny5_r;
  logic signed [CMP_W-1:0] qxl5_r, qxh5_r, qyl5_r, qyh5_r;
  logic signed [CMP_W-1:0] bxl5_r, bxh5_r, byl5_r, byh5_r;

  logic hit_r;

  logic signed [CMP_W-1:0] nx_raw, ny_raw;
  logic                    det_neg;
  logic                    in_range;

  assign nx_raw  = CMP_W'(na3_r) - CMP_W'(nb3_r);
  assign ny_raw  = CMP_W'(nc3_r) - CMP_W'(nd3_r);
  assign det_neg = det3_r[DET_W-1];

  assign in_range = (nx5_r >= qxl5_r) && (nx5_r <= qxh5_r) &&
                    (nx5_r >= bxl5_r) && (nx5_r <= bxh5_r) &&
                    (ny5_r >= qyl5_r) && (ny5_r <= qyh5_r) &&
                    (ny5_r >= byl5_r) && (ny5_r <= byh5_r);

  // Payload registers
  always_ff @(posedge clk) begin
    if (vld) begin
      prev_r <= pt;
    end
    // stage 1
    x3_1_r <= px;
    y3_1_r <= py;
    x4_1_r <= qx;
    y4_1_r <= qy;
    dxb1_r <= DIF_W'(px) - DIF_W'(qx);
    dyb1_r <= DIF_W'(py) - DIF_W'(qy);
    m1_1_r <= CP_W'(px) * CP_W'(qy);
    m2_1_r <= CP_W'(py) * CP_W'(qx);
    // stage 2
    x3_2_r  <= x3_1_r;
    y3_2_r  <= y3_1_r;
    x4_2_r  <= x4_1_r;
    y4_2_r  <= y4_1_r;
    dxb2_r  <= dxb1_r;
    dyb2_r  <= dyb1_r;
    cb2_r   <= CA_W'(m1_1_r) - CA_W'(m2_1_r);
    pd1_2_r <= DP_W'(qry.dxa) * DP_W'(dyb1_r);
    pd2_2_r <= DP_W'(qry.dya) * DP_W'(dxb1_r);
    // stage 3
    x3_3_r <= x3_2_r;
    y3_3_r <= y3_2_r;
    x4_3_r <= x4_2_r;
    y4_3_r <= y4_2_r;
    det3_r <= DET_W'(pd1_2_r) - DET_W'(pd2_2_r);
    na3_r  <= NP_W'(dxb2_r) * NP_W'(qry.ca);
    nb3_r  <= NP_W'(qry.dxa) * NP_W'(cb2_r);
    nc3_r  <= NP_W'(dyb2_r) * NP_W'(qry.ca);
    nd3_r  <= NP_W'(qry.dya) * NP_W'(cb2_r);
    // stage 4
    adet4_r <= det_neg ? -det3_r : det3_r;
    nx4_r   <= det_neg ? -nx_raw : nx_raw;
    ny4_r   <= det_neg ? -ny_raw : ny_raw;
    bxl4_r  <= (x3_3_r < x4_3_r) ? x3_3_r : x4_3_r;
    bxh4_r  <= (x3_3_r < x4_3_r) ? x4_3_r : x3_3_r;
    byl4_r  <= (y3_3_r < y4_3_r) ? y3_3_r : y4_3_r;
    byh4_r  <= (y3_3_r < y4_3_r) ? y4_3_r : y3_3_r;
    // stage 5
    nx5_r  <= nx4_r;
    ny5_r  <= ny4_r;
    qxl5_r <= CMP_W'(qry.qxl) * CMP_W'(adet4_r);
    qxh5_r <= CMP_W'(qry.qxh) * CMP_W'(adet4_r);
    qyl5_r <= CMP_W'(qry.qyl) * CMP_W'(adet4_r);
    qyh5_r <= CMP_W'(qry.qyh) * CMP_W'(adet4_r);
    bxl5_r <= CMP_W'(bxl4_r) * CMP_W'(adet4_r);
    bxh5_r <= CMP_W'(bxh4_r) * CMP_W'(adet4_r);
    byl5_r <= CMP_W'(byl4_r) * CMP_W'(adet4_r);
    byh5_r <= CMP_W'(byh4_r) * CMP_W'(adet4_r);
  end

  // Stage valids and sticky hit; zero determinant drops out at stage 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r  <= vld && !first;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r && (det3_r != '0);
      v5_r  <= v4_r;
      hit_r <= clr ? 1'b0 : (hit_r || (v5_r && in_range));
    end
  end

  assign stat.busy = v1_r || v2_r || v3_r || v4_r || v5_r;
  assign stat.hit  = hit_r;

endmodule

// File: rtl/trail_segment_collision_core.sv
// Trail segment collision core: append, clear and segment query over stored trails.
// Append, clear and unused-code words: result registered in the cycle after acceptance, one
// per cycle while the result channel is ready. Query: points are read from point memory one
// per cycle, with a pause at each trail change, into a 5-stage crossing pipe; input waits.
// Synchronous active-low reset empties all trails and idles the sequencer;
// the point memory is not cleared and needs no clearing pass.
`include "trail_segment_collision_core_macros.svh"

module trail_segment_collision_core #(
  parameter int TRAILS           = tsc_pkg::TRAILS_DEF,
  parameter int POINTS_PER_TRAIL = tsc_pkg::PPT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tsc_in_if.sink    in_ch,
  tsc_out_if.source out_ch
);

  localparam int DEPTH = TRAILS * POINTS_PER_TRAIL;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(POINTS_PER_TRAIL + 1);
  localparam int TIW   = (TRAILS > 1) ? $clog2(TRAILS) : 1;
  localparam int CRD_W = tsc_pkg::CRD_W;
  localparam int DIF_W = tsc_pkg::DIF_W;
  localparam int CP_W  = tsc_pkg::CP_W;
  localparam int CA_W  = tsc_pkg::CA_W;
  localparam int PC_W  = tsc_pkg::PC_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LW-1:0]           len_r [TRAILS];
  logic [TIW-1:0]          t_r, t_nxt;
  logic [LW-1:0]           i_r, i_nxt;
  logic [AW-1:0]           base_r, base_nxt;
  logic                    rd_pend_r, rd_first_r;
  logic signed [CRD_W-1:0] qx1_r, qy1_r, qx2_r, qy2_r;
  tsc_pkg::qry_t           qry_r, qry_nxt;
  logic [PC_W-1:0]         qcnt_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic [PC_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic                    out_drop_r, out_drop_nxt;

  logic                in_ready, acc, tid_ok, full;
  logic [TIW-1:0]      len_idx;
  logic [LW-1:0]       len_rd;
  logic [PC_W-1:0]     cnt_now;
  logic                we, rd_en, rd_first, finish;
  logic [AW-1:0]       waddr, raddr;
  logic [tsc_pkg::PT_W-1:0] rdata;
  logic signed [CP_W-1:0]   ca_m1, ca_m2;
  tsc_pkg::pipe_stat_t pstat;

  // Input handshake and addressed trail
  assign in_ready    = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;
  assign tid_ok      = 32'(in_ch.trail_id) < TRAILS;
  assign len_idx     = (state_r == ST_IDLE) ? TIW'(in_ch.trail_id) : t_r;
  assign len_rd      = len_r[len_idx];
  assign full        = len_rd >= LW'(POINTS_PER_TRAIL);
  assign cnt_now     = tid_ok ? PC_W'(len_rd) : '0;

  // Point write on append
  assign we    = acc && (in_ch.action == tsc_pkg::ACT_APPEND) && tid_ok && !full;
  assign waddr = AW'(in_ch.trail_id) * AW'(POINTS_PER_TRAIL) + AW'(len_rd);

  // Query setup terms
  assign ca_m1 = CP_W'(qx1_r) * CP_W'(qy2_r);
  assign ca_m2 = CP_W'(qy1_r) * CP_W'(qx2_r);

  always_comb begin
    qry_nxt.qxl = (qx1_r < qx2_r) ? qx1_r : qx2_r;
    qry_nxt.qxh = (qx1_r < qx2_r) ? qx2_r : qx1_r;
    qry_nxt.qyl = (qy1_r < qy2_r) ? qy1_r : qy2_r;
    qry_nxt.qyh = (qy1_r < qy2_r) ? qy2_r : qy1_r;
    qry_nxt.dxa = DIF_W'(qx1_r) - DIF_W'(qx2_r);
    qry_nxt.dya = DIF_W'(qy1_r) - DIF_W'(qy2_r);
    qry_nxt.ca  = CA_W'(ca_m1) - CA_W'(ca_m2);
  end

  // Sequencer: walk each trail's points, then drain the pipe
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    i_nxt     = i_r;
    base_nxt  = base_r;
    rd_en     = 1'b0;
    rd_first  = 1'b0;
    raddr     = base_r + AW'(i_r);
    finish    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (in_ch.action == tsc_pkg::ACT_QUERY)) begin
          state_nxt = ST_SETUP;
          t_nxt     = '0;
          i_nxt     = '0;
          base_nxt  = '0;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (i_r < len_rd) begin
          rd_en    = 1'b1;
          rd_first = (i_r == '0);
          i_nxt    = i_r + 1'b1;
        end else begin
          i_nxt = '0;
          if (t_r == TIW'(TRAILS - 1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            t_nxt    = t_r + 1'b1;
            base_nxt = base_r + AW'(POINTS_PER_TRAIL);
          end
        end
      end
      ST_DRAIN: begin
        if (!rd_pend_r && !pstat.busy && (!out_valid_r || out_ch.ready)) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result word
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_cnt_nxt   = out_cnt_r;
    out_drop_nxt  = out_drop_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = pstat.hit;
      out_cnt_nxt   = qcnt_r;
      out_drop_nxt  = 1'b0;
    end else if (acc) begin
      case (in_ch.action)
        tsc_pkg::ACT_APPEND: begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_cnt_nxt   = !tid_ok ? '0 : (full ? PC_W'(len_rd) : PC_W'(len_rd + 1'b1));
          out_drop_nxt  = tid_ok && full;
        end
        tsc_pkg::ACT_QUERY: begin
          out_valid_nxt = out_valid_r && !out_ch.ready;
        end
        default: begin
          // clear and the unused code both report zeros
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_cnt_nxt   = '0;
          out_drop_nxt  = 1'b0;
        end
      endcase
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < TRAILS; k++) begin
        len_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        len_r[len_idx] <= len_rd + 1'b1;
      end else if (acc && (in_ch.action == tsc_pkg::ACT_CLEAR) && tid_ok) begin
        len_r[len_idx] <= '0;
      end
    end
    t_r        <= t_nxt;
    i_r        <= i_nxt;
    base_r     <= base_nxt;
    rd_first_r <= rd_first;
    out_hit_r  <= out_hit_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_drop_r <= out_drop_nxt;
    if (state_r == ST_SETUP) begin
      qry_r <= qry_nxt;
    end
    if (acc && (in_ch.action == tsc_pkg::ACT_QUERY)) begin
      qx1_r  <= in_ch.x_first;
      qy1_r  <= in_ch.y_first;
      qx2_r  <= in_ch.x_second;
      qy2_r  <= in_ch.y_second;
      qcnt_r <= cnt_now;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.point_count = out_cnt_r;
  assign out_ch.dropped     = out_drop_r;

  tsc_point_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({in_ch.y_first, in_ch.x_first}),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsc_seg_pipe u_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (acc && (in_ch.action == tsc_pkg::ACT_QUERY)),
    .vld   (rd_pend_r),
    .first (rd_first_r),
    .pt    (rdata),
    .qry   (qry_r),
    .stat  (pstat)
  );

  // Checks
  `TSC_CHECK(a_write_idle, we, state_r == ST_IDLE, "point write outside idle")
  `TSC_CHECK(a_read_walk, rd_pend_r, state_r == ST_WALK || state_r == ST_DRAIN,
    "read data pending outside a query walk")
  `TSC_CHECK(a_len_bound, 1'b1, len_rd <= LW'(POINTS_PER_TRAIL), "trail length overflow")
  `TSC_CHECK_NXT(a_finish_out, finish, out_valid_r && state_r == ST_IDLE,
    "query finish did not post a result")

endmodule
